@@ rtl/modular_exponentiation_macros.svh @@
// Assertion macros for the modular exponentiation block.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ME_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define ME_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ rtl/modexp_pkg.sv @@
// Package: widths and shared types for the modular exponentiation block.
package modexp_pkg;
	localparam int WIDTH = 32;
	localparam int CNT_W = $clog2(WIDTH + 1);
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;
	typedef logic [WIDTH-1:0] word_t;
	localparam logic REG_EXPONENT = 1'b0;
	localparam logic REG_MODULUS = 1'b1;
	// Queue entry: base plus classification by the front end.
	typedef struct packed {
		word_t base;
		logic  exp_zero;
		logic  mod_zero;
	} job_t;
endpackage

@@ rtl/modexp_front.sv @@
// Front end: accepts base values, classifies them, and queues jobs.
module modexp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  modexp_pkg::word_t    base_value,
	input  modexp_pkg::word_t    exponent_q,
	input  modexp_pkg::word_t    modulus_q,
	output logic                 job_valid,
	input  logic                 job_ready,
	output modexp_pkg::job_t     job
);
	modexp_pkg::job_t mem_q [modexp_pkg::QDEPTH];
	logic [modexp_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [modexp_pkg::QCNT_W-1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != modexp_pkg::QCNT_W'(modexp_pkg::QDEPTH));
	assign job_valid = (cnt_q != '0);
	assign push = in_valid && in_ready;
	assign pop = job_valid && job_ready;
	assign job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{base: base_value, exp_zero: (exponent_q == '0),
				mod_zero: (modulus_q == '0)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

@@ rtl/modexp_mulmod.sv @@
// Shared modular multiplier: shift-and-add, one multiplier bit per cycle.
module modexp_mulmod (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  modexp_pkg::word_t  a,
	input  modexp_pkg::word_t  b,
	input  modexp_pkg::word_t  m,
	output logic               busy,
	output logic               done,
	output modexp_pkg::word_t  p
);
	localparam int W = modexp_pkg::WIDTH;
	localparam logic ST_IDLE = 1'b0, ST_RUN = 1'b1;
	logic st_q;
	modexp_pkg::word_t a_q, b_q, m_q, acc_q;
	logic [modexp_pkg::CNT_W-1:0] cnt_q;
	logic [W:0] dbl, dbl_r, sum, sum_r;
	modexp_pkg::word_t wrap_sum, nxt;

	// acc < m and addend a <= m keep every partial sum below 2m: one subtract each.
	assign dbl = {acc_q, 1'b0};
	assign dbl_r = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
	assign sum = b_q[W-1] ? dbl_r + {1'b0, a_q} : dbl_r;
	assign sum_r = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
	// modulus zero: plain product wrapping at the word width
	assign wrap_sum = dbl[W-1:0] + (b_q[W-1] ? a_q : '0);
	assign nxt = (m_q == '0) ? wrap_sum : sum_r[W-1:0];
	assign busy = (st_q == ST_RUN);
	assign p = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (start) st_q <= ST_RUN;
				ST_RUN: if (cnt_q == modexp_pkg::CNT_W'(1)) begin
					st_q <= ST_IDLE;
					done <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) begin
			a_q <= a;
			b_q <= b;
			m_q <= m;
			acc_q <= '0;
			cnt_q <= modexp_pkg::CNT_W'(W);
		end else if (st_q == ST_RUN) begin
			acc_q <= nxt;
			b_q <= {b_q[W-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

@@ rtl/modexp_back.sv @@
// Back end: runs the exponent bit loop on the shared modular multiplier.
module modexp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  modexp_pkg::job_t   job,
	input  modexp_pkg::word_t  exponent_q,
	input  modexp_pkg::word_t  modulus_q,
	output logic               out_valid,
	input  logic               out_ready,
	output modexp_pkg::word_t  power_result
);
	localparam int W = modexp_pkg::WIDTH;
	localparam logic [2:0] ST_IDLE = 3'd0, ST_MUL = 3'd1, ST_WMUL = 3'd2,
		ST_SQR = 3'd3, ST_WSQR = 3'd4, ST_OUT = 3'd5, ST_RED = 3'd6, ST_WRED = 3'd7;
	logic [2:0] st_q;
	modexp_pkg::word_t res_q, sq_q, e_q, ma, mb, mp;
	logic mstart, mbusy, mdone;

	modexp_mulmod u_mul (.clk, .arst_n, .start(mstart), .a(ma), .b(mb),
		.m(modulus_q), .busy(mbusy), .done(mdone), .p(mp));

	assign job_ready = (st_q == ST_IDLE);
	assign out_valid = (st_q == ST_OUT);
	assign power_result = res_q;
	assign mstart = (st_q == ST_RED || st_q == ST_MUL || st_q == ST_SQR) && !mbusy;
	// base reduction is base * 1 mod m, so the square operand stays below m
	assign ma = (st_q == ST_RED) ? modexp_pkg::word_t'(1) :
		(st_q == ST_MUL) ? res_q : sq_q;
	assign mb = sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE: if (job_valid) begin
					if (job.exp_zero) st_q <= ST_OUT;
					else st_q <= ST_RED;
				end
				ST_RED: if (!mbusy) st_q <= ST_WRED;
				ST_WRED: if (mdone) st_q <= e_q[0] ? ST_MUL : ST_SQR;
				ST_MUL: if (!mbusy) st_q <= ST_WMUL;
				ST_WMUL: if (mdone) st_q <= (e_q[W-1:1] == '0) ? ST_OUT : ST_SQR;
				ST_SQR: if (!mbusy) st_q <= ST_WSQR;
				ST_WSQR: if (mdone) st_q <= e_q[1] ? ST_MUL : ST_SQR;
				ST_OUT: if (out_ready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: if (job_valid) begin
				res_q <= modexp_pkg::word_t'(1);
				sq_q <= job.base;
				e_q <= exponent_q;
			end
			ST_WRED: if (mdone) sq_q <= mp;
			ST_WMUL: if (mdone) res_q <= mp;
			ST_WSQR: if (mdone) begin
				sq_q <= mp;
				e_q <= e_q >> 1;
			end
			default: ;
		endcase
	end
endmodule

@@ rtl/modular_exponentiation.sv @@
// Modular exponentiation top level: config registers, front end, back end.
// Sequence (back end idle): an exponent of zero goes straight to out_valid with result 1;
//   else the job takes 1 + ones(e) + msb_index(e) modular multiplies (reduction, multiplies, squares).
// Flow: one transaction at a time in the back end, which takes no new job until the result
//   is accepted; the two-entry queue drops in_ready when full.
// Reset (arst_n low): exponent 0, modulus 1, queue and sequencers empty.
`include "modular_exponentiation_macros.svh"
module modular_exponentiation (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  modexp_pkg::word_t        cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  modexp_pkg::word_t        base_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output modexp_pkg::word_t        power_result
);
	modexp_pkg::word_t exponent_q, modulus_q;
	modexp_pkg::job_t job;
	logic job_valid, job_ready;

	// Configuration registers; the user must write them only while idle, the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= '0;
			modulus_q <= modexp_pkg::word_t'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				modexp_pkg::REG_EXPONENT: exponent_q <= cfg_data;
				modexp_pkg::REG_MODULUS: modulus_q <= cfg_data;
				default: ;
			endcase
		end
	end

	modexp_front u_front (.clk, .arst_n, .in_valid, .in_ready, .base_value,
		.exponent_q, .modulus_q, .job_valid, .job_ready, .job);

	modexp_back u_back (.clk, .arst_n, .job_valid, .job_ready, .job,
		.exponent_q, .modulus_q, .out_valid, .out_ready, .power_result);

	`ME_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(power_result))
	`ME_ASSERT_IMP(a_job_when_out, out_valid, !job_ready)
endmodule

@@ verif/modular_exponentiation_checker.sv @@
// Checker: predicts modular powers from observed transactions and compares results.
`timescale 1ns / 1ps
module modular_exponentiation_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  modexp_pkg::word_t cfg_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  modexp_pkg::word_t base_value,
	input  logic              out_valid,
	input  logic              out_ready,
	input  modexp_pkg::word_t power_result,
	output int                fail_count,
	output int                powers_pending
);
	modexp_pkg::word_t exp_shadow;
	modexp_pkg::word_t mod_shadow;
	modexp_pkg::word_t expected_powers[$];

	// exact product mod m; m of zero wraps at the word width
	function automatic modexp_pkg::word_t mul_reduce(modexp_pkg::word_t a,
		modexp_pkg::word_t b, modexp_pkg::word_t m);
		logic [2*modexp_pkg::WIDTH-1:0] prod;
		if (m == '0) begin
			prod = a * b;
			return prod[modexp_pkg::WIDTH-1:0];
		end
		prod = (a % m) * (b % m);
		return modexp_pkg::word_t'(prod % m);
	endfunction

	function automatic modexp_pkg::word_t mod_power(modexp_pkg::word_t b,
		modexp_pkg::word_t e, modexp_pkg::word_t m);
		modexp_pkg::word_t acc;
		modexp_pkg::word_t sq;
		acc = modexp_pkg::word_t'(1);
		sq = b;
		while (e != '0) begin
			if (e[0])
				acc = mul_reduce(acc, sq, m);
			e = e >> 1;
			sq = mul_reduce(sq, sq, m);
		end
		return acc;
	endfunction

	assign powers_pending = expected_powers.size();

	always @(posedge clk or negedge arst_n) begin
		modexp_pkg::word_t want;
		if (!arst_n) begin
			exp_shadow <= '0;
			mod_shadow <= modexp_pkg::word_t'(1);
			fail_count <= 0;
			expected_powers.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == modexp_pkg::REG_EXPONENT)
					exp_shadow <= cfg_data;
				else
					mod_shadow <= cfg_data;
			end
			if (in_valid && in_ready)
				expected_powers.push_back(mod_power(base_value, exp_shadow, mod_shadow));
			if (out_valid && out_ready) begin
				if (expected_powers.size() == 0) begin
					$error("power_result: unexpected transaction, actual %h", power_result);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_powers.pop_front();
					if (power_result !== want) begin
						$error("power_result: expected %h, actual %h", want, power_result);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

@@ verif/modular_exponentiation_tb.sv @@
// Testbench top: clock, reset, config phases, base stimulus and verdict.
`timescale 1ns / 1ps
module modular_exponentiation_tb;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int STALL_CYCLES = 400;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	modexp_pkg::word_t cfg_data;
	logic              in_valid;
	logic              in_ready;
	modexp_pkg::word_t base_value;
	logic              out_valid;
	logic              out_ready;
	modexp_pkg::word_t power_result;
	int                fail_count;
	int                powers_pending;

	int    tx_idle_pct;
	int    rx_idle_pct;
	logic  rx_hold;
	int    cycle_count;
	int    bases_sent;

	modular_exponentiation dut (.*);

	modular_exponentiation_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: random backpressure, or a long hold-off when rx_hold is set
	always @(negedge clk) begin
		if (rx_hold)
			out_ready = 1'b0;
		else
			out_ready = ($urandom_range(99) >= rx_idle_pct);
	end

	// config write; only called with the block drained
	task automatic write_reg(logic idx, modexp_pkg::word_t value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// one base transaction; valid stays up across back-to-back items
	task automatic send_base(modexp_pkg::word_t value);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		base_value = value;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		bases_sent++;
		// idle profile moves with overall progress
		if (bases_sent < 90) begin
			tx_idle_pct = 20;
			rx_idle_pct = 63;
		end else if (bases_sent < 180) begin
			tx_idle_pct = 63;
			rx_idle_pct = 20;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
	endtask

	// first items of each phase hit the edges around the modulus
	function automatic modexp_pkg::word_t pick_base(int k, modexp_pkg::word_t m);
		unique case (k)
			0: return '0;
			1: return modexp_pkg::word_t'(1);
			2: return '1;
			3: return m - 1'b1;
			4: return m;
			5: return m + 1'b1;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_phase(modexp_pkg::word_t e, modexp_pkg::word_t m, int n, bit do_write);
		if (do_write) begin
			write_reg(modexp_pkg::REG_EXPONENT, e);
			write_reg(modexp_pkg::REG_MODULUS, m);
		end
		for (int k = 0; k < n; k++)
			send_base(pick_base(k, m));
		in_valid = 1'b0;
		wait (powers_pending == 0);
		@(negedge clk);
	endtask

	initial begin
		modexp_pkg::word_t e;
		modexp_pkg::word_t m;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = modexp_pkg::REG_EXPONENT;
		cfg_data = '0;
		in_valid = 1'b0;
		base_value = '0;
		rx_hold = 1'b0;
		bases_sent = 0;
		tx_idle_pct = 20;
		rx_idle_pct = 63;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: exponent zero gives 1 even with modulus 1
		run_phase('0, 1, 10, 1'b0);
		run_phase(1, 1, 10, 1'b1);
		run_phase(65537, '1, 40, 1'b1);
		run_phase('1, 32'hFFFF_FFFB, 20, 1'b1);

		// fast items: hold the receiver off so the queue fills and input stalls
		fork
			begin
				rx_hold = 1'b1;
				repeat (STALL_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end
			run_phase('0, $urandom | 32'h1, 40, 1'b1);
		join

		run_phase(3, 2, 20, 1'b1);
		repeat (4) begin
			e = $urandom >> $urandom_range(31);
			m = $urandom >> $urandom_range(31);
			if (m == '0)
				m = 1;
			run_phase(e, m, 30, 1'b1);
		end

		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/modexp_pkg.sv
rtl/modexp_front.sv
rtl/modexp_mulmod.sv
rtl/modexp_back.sv
rtl/modular_exponentiation.sv
verif/modular_exponentiation_checker.sv
verif/modular_exponentiation_tb.sv
